FILE: src/ycs_pkg.sv
package ycs_pkg;

    localparam int LumaWidth   = 8;
    localparam int ChanWidth   = 8;
    localparam int ChromaWidth = 8;
    localparam int ProdWidth   = 17;
    localparam int TermWidth   = 10;
    localparam int SumWidth    = 11;
    localparam int SlotWidth   = 2;
    localparam int LumaCount   = 4;

    localparam logic [1:0] FMT_YUYV = 2'd0;
    localparam logic [1:0] FMT_NV12 = 2'd1;
    localparam logic [1:0] FMT_NV21 = 2'd2;

    localparam logic [SlotWidth-1:0] SLOT_PAIR_LAST = 2'd1;
    localparam logic [SlotWidth-1:0] SLOT_QUAD_LAST = 2'd3;

    localparam logic signed [ProdWidth-1:0] K_RV = 17'sd103;
    localparam logic signed [ProdWidth-1:0] K_GU = 17'sd88;
    localparam logic signed [ProdWidth-1:0] K_GV = 17'sd183;
    localparam logic signed [ProdWidth-1:0] K_BU = 17'sd197;

    localparam logic signed [SumWidth-1:0] CHAN_MAX = 11'sd255;

    typedef logic [LumaWidth-1:0] luma_t;

    typedef struct packed {
        luma_t [LumaCount-1:0]        luma;
        logic signed [TermWidth-1:0]  rt;
        logic signed [TermWidth-1:0]  gt;
        logic signed [TermWidth-1:0]  bt;
        logic                         quad;
        logic                         fend;
    } group_t;

    function automatic logic [ChanWidth-1:0] clamp8(input logic signed [SumWidth-1:0] s);
        logic [ChanWidth-1:0] r;
        if (s < 0)
        begin
            r = '0;
        end
        else if (s > CHAN_MAX)
        begin
            r = '1;
        end
        else
        begin
            r = s[ChanWidth-1:0];
        end
        return r;
    endfunction

endpackage

FILE: src/yuv_chroma_shared_to_rgb888.sv
// Converts one chroma-sharing group per input word into RGB888 pixels, one pixel per output
// word in slot order a, b, c, d: two pixels in YUYV mode, four in NV12 and NV21 modes, where
// NV21 takes the chroma bytes in V, U order. The shared color terms pass through three
// registered stages (chroma capture, constant multiplies, term sums), and a serializer then
// adds each luma, clamps and registers one pixel per cycle while the output is not stalled.
// The pipeline takes a new group every cycle while the serializer has room. The
// color_format register lies at byte address 0; it is to be written only while the block
// is idle, which the block itself does not enforce.
module yuv_chroma_shared_to_rgb888 (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    // luma_a, luma_b, luma_c, luma_d, chroma_first, chroma_second
    input  logic [47:0] s_tdata,
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // red, green, blue, pixel_slot, zero padding
    output logic [31:0] m_tdata,
    output logic        m_tlast,
    // frame_done
    output logic        m_tuser
);
    import ycs_pkg::*;

    logic [1:0] fmt_reg;
    logic       grp_valid, grp_ready;
    group_t     grp;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {30'd0, fmt_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg <= FMT_YUYV;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0))
        begin
            fmt_reg <= pwdata[1:0];
        end
    end

    ycs_terms u_terms (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_data      (s_tdata),
        .in_fend      (s_tlast),
        .color_format (fmt_reg),
        .grp_valid    (grp_valid),
        .grp_ready    (grp_ready),
        .grp          (grp)
    );

    ycs_serializer u_ser (
        .clk       (clk),
        .rst_n     (rst_n),
        .grp_valid (grp_valid),
        .grp_ready (grp_ready),
        .grp       (grp),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_last  (m_tlast),
        .out_fdone (m_tuser)
    );

endmodule

FILE: src/ycs_terms.sv
module ycs_terms (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [47:0]         in_data,
    input  logic                in_fend,
    input  logic [1:0]          color_format,
    output logic                grp_valid,
    input  logic                grp_ready,
    output ycs_pkg::group_t     grp
);
    import ycs_pkg::*;

    logic en1, en2, en3;
    logic v1_reg, v2_reg, v3_reg;

    luma_t [LumaCount-1:0]          luma1_reg, luma2_reg;
    logic signed [ChromaWidth-1:0]  u1_reg, v1d_reg;
    logic signed [ChromaWidth-1:0]  u2_reg, v2d_reg;
    logic                           quad1_reg, quad2_reg, fend1_reg, fend2_reg;
    logic signed [ProdWidth-1:0]    p_rv_reg, p_gu_reg, p_gv_reg, p_bu_reg;
    group_t                         grp_reg;

    logic [ChromaWidth-1:0]         c_first, c_second;
    logic signed [ChromaWidth-1:0]  u_next, v_next;
    logic                           swap;

    assign en3      = !v3_reg || grp_ready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    assign c_first  = in_data[39:32];
    assign c_second = in_data[47:40];
    assign swap     = (color_format == FMT_NV21);
    // Flipping the top bit of a byte subtracts the offset of 128.
    assign u_next   = swap ? $signed({~c_second[7], c_second[6:0]})
                           : $signed({~c_first[7], c_first[6:0]});
    assign v_next   = swap ? $signed({~c_first[7], c_first[6:0]})
                           : $signed({~c_second[7], c_second[6:0]});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && in_valid)
        begin
            luma1_reg <= in_data[31:0];
            u1_reg    <= u_next;
            v1d_reg   <= v_next;
            quad1_reg <= (color_format == FMT_NV12) || (color_format == FMT_NV21);
            fend1_reg <= in_fend;
        end
        if (en2 && v1_reg)
        begin
            luma2_reg <= luma1_reg;
            u2_reg    <= u1_reg;
            v2d_reg   <= v1d_reg;
            quad2_reg <= quad1_reg;
            fend2_reg <= fend1_reg;
            p_rv_reg  <= ProdWidth'(v1d_reg) * K_RV;
            p_gu_reg  <= ProdWidth'(u1_reg) * K_GU;
            p_gv_reg  <= ProdWidth'(v1d_reg) * K_GV;
            p_bu_reg  <= ProdWidth'(u1_reg) * K_BU;
        end
        if (en3 && v2_reg)
        begin
            grp_reg.luma <= luma2_reg;
            grp_reg.rt   <= TermWidth'(v2d_reg) + TermWidth'($signed(p_rv_reg[16:8]));
            grp_reg.gt   <= TermWidth'($signed(p_gu_reg[16:8]))
                          + TermWidth'($signed(p_gv_reg[16:8]));
            grp_reg.bt   <= TermWidth'(u2_reg) + TermWidth'($signed(p_bu_reg[16:8]));
            grp_reg.quad <= quad2_reg;
            grp_reg.fend <= fend2_reg;
        end
    end

    assign grp_valid = v3_reg;
    assign grp       = grp_reg;

endmodule

FILE: src/ycs_serializer.sv
module ycs_serializer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                grp_valid,
    output logic                grp_ready,
    input  ycs_pkg::group_t     grp,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [31:0]         out_data,
    output logic                out_last,
    output logic                out_fdone
);
    import ycs_pkg::*;

    logic                  hold_valid_reg, hold_valid_next;
    logic [SlotWidth-1:0]  slot_reg, slot_next;
    group_t                hold_reg;
    logic                  ov_reg, ov_next;
    logic [ChanWidth-1:0]  red_reg, green_reg, blue_reg;
    logic [SlotWidth-1:0]  oslot_reg;
    logic                  olast_reg, ofdone_reg;

    logic                  out_free, emit, is_last, load;
    luma_t                 y;
    logic signed [SumWidth-1:0] y_s, sum_r, sum_g, sum_b;

    assign out_free  = !ov_reg || out_ready;
    assign emit      = hold_valid_reg && out_free;
    assign is_last   = hold_reg.quad ? (slot_reg == SLOT_QUAD_LAST)
                                     : (slot_reg == SLOT_PAIR_LAST);
    assign grp_ready = !hold_valid_reg || (emit && is_last);
    assign load      = grp_valid && grp_ready;

    assign y     = hold_reg.luma[slot_reg];
    assign y_s   = $signed({3'b000, y});
    assign sum_r = y_s + SumWidth'(hold_reg.rt);
    assign sum_g = y_s - SumWidth'(hold_reg.gt);
    assign sum_b = y_s + SumWidth'(hold_reg.bt);

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        slot_next       = slot_reg;
        ov_next         = ov_reg && !out_ready;
        if (emit)
        begin
            ov_next = 1'b1;
            if (is_last)
            begin
                hold_valid_next = 1'b0;
            end
            else
            begin
                slot_next = slot_reg + 1'b1;
            end
        end
        if (load)
        begin
            hold_valid_next = 1'b1;
            slot_next       = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            slot_reg       <= '0;
            ov_reg         <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            slot_reg       <= slot_next;
            ov_reg         <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            hold_reg <= grp;
        end
        if (emit)
        begin
            red_reg    <= clamp8(sum_r);
            green_reg  <= clamp8(sum_g);
            blue_reg   <= clamp8(sum_b);
            oslot_reg  <= slot_reg;
            olast_reg  <= is_last;
            ofdone_reg <= is_last && hold_reg.fend;
        end
    end

    assign out_valid = ov_reg;
    assign out_data  = {6'b000000, oslot_reg, blue_reg, green_reg, red_reg};
    assign out_last  = olast_reg;
    assign out_fdone = ofdone_reg;

endmodule

FILE: src/ycs_checker.sv
module ycs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast,
    input logic        m_tuser
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    a_fdone_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("frame_done on a pixel that is not the last of its group");

    a_last_slot: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> (m_tdata[25:24] == 2'd1) || (m_tdata[25:24] == 2'd3))
        else $error("group ended on a wrong pixel slot");

    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[31:26] == 6'd0) && !(m_tlast && (m_tdata[25:24] == 2'd0)))
        else $error("bad padding or slot code");

endmodule

bind yuv_chroma_shared_to_rgb888 ycs_checker u_ycs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
